>>> hw/rtl/stnv_pkg.sv
// ----------------------------------------------------------------------------
// stnv_pkg
// Shared types, codes and constants of the swept tone / noise voice.
// ----------------------------------------------------------------------------
package stnv_pkg;

  // field widths fixed by the register map and the sample formats
  localparam int FREQ_W     = 14;
  localparam int AMP_W      = 15;
  localparam int WAVE_W     = 2;
  localparam int DECAY_W    = 10;
  localparam int DUR_W      = 16;
  localparam int MIX_W      = 18;
  localparam int PCM_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MUL_W      = 18;
  localparam int PROD_W     = 2 * MUL_W;

  // sweep numerator start*(d-i) + end*i stays below 2^(FREQ_W+DUR_W)
  localparam int SWEEP_NUM_W = FREQ_W + DUR_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_FREQ = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_FREQ   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION   = 3'd5;

  // waveform codes
  localparam logic [WAVE_W-1:0] WAVE_SQUARE = 2'd0;
  localparam logic [WAVE_W-1:0] WAVE_SAW    = 2'd1;
  localparam logic [WAVE_W-1:0] WAVE_SINE   = 2'd2;
  localparam logic [WAVE_W-1:0] WAVE_NOISE  = 2'd3;

  // register reset values
  localparam logic [FREQ_W-1:0]  RST_START_FREQ = 14'd440;
  localparam logic [FREQ_W-1:0]  RST_END_FREQ   = 14'd440;
  localparam logic [AMP_W-1:0]   RST_AMPLITUDE  = 15'd0;
  localparam logic [WAVE_W-1:0]  RST_WAVEFORM   = WAVE_SINE;
  localparam logic [DECAY_W-1:0] RST_DECAY_RATE = 10'd96;
  localparam logic [DUR_W-1:0]   RST_DURATION   = 16'd2205;

  // noise source and lowpass weights (0.6 and 0.4 in Q15)
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam int LP_KEEP = 19661;
  localparam int LP_NEW  = 13107;

  // quarter sine polynomial coefficients
  localparam int SIN_A = 102944;
  localparam int SIN_B = 42331;
  localparam int SIN_C = 4923;

  // pcm scaling
  localparam int PCM_SCALE = 32000;

  // envelope: x in 1/64 steps, integer part from a table, fraction by bits
  localparam int ENV_FRAC_W  = 6;
  localparam int ENV_BIT_W   = 3;
  localparam int EXP_INT_N   = 12;
  localparam int ENV_X_LIMIT = EXP_INT_N * 64;

  // exp(-k) in Q1.15
  function automatic logic [15:0] exp_int(input logic [3:0] k);
    logic [15:0] v;
    case (k)
      4'd0:    v = 16'd32768;
      4'd1:    v = 16'd12055;
      4'd2:    v = 16'd4435;
      4'd3:    v = 16'd1631;
      4'd4:    v = 16'd600;
      4'd5:    v = 16'd221;
      4'd6:    v = 16'd81;
      4'd7:    v = 16'd30;
      4'd8:    v = 16'd11;
      4'd9:    v = 16'd4;
      4'd10:   v = 16'd1;
      4'd11:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // exp(-2^b/64) in Q15
  function automatic logic [14:0] exp_frac(input logic [ENV_BIT_W-1:0] b);
    logic [14:0] v;
    case (b)
      3'd0:    v = 15'd32260;
      3'd1:    v = 15'd31760;
      3'd2:    v = 15'd30783;
      3'd3:    v = 15'd28918;
      3'd4:    v = 15'd25520;
      3'd5:    v = 15'd19875;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // datapath micro-operations, one per cycle
  typedef enum logic [5:0] {
    OP_NONE,
    OP_LOAD,
    OP_CHECK,
    OP_M_DI,
    OP_DIV_ENV,
    OP_W_ENV0,
    OP_M_ENV,
    OP_W_ENV,
    OP_M_F0,
    OP_W_F0,
    OP_M_F1,
    OP_W_F1,
    OP_M_SRD,
    OP_DIV_INC,
    OP_W_INC,
    OP_LFSR,
    OP_M_N1,
    OP_W_N1,
    OP_M_N2,
    OP_W_N2,
    OP_M_S1,
    OP_W_S1,
    OP_M_S2,
    OP_W_S2,
    OP_M_S3,
    OP_W_S3,
    OP_M_S4,
    OP_W_S4,
    OP_M_VA,
    OP_W_VA,
    OP_M_VE,
    OP_W_VE,
    OP_M_PCM,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t                op;
    logic [ENV_BIT_W-1:0]  env_bit;
  } dp_cmd_t;

  typedef struct packed {
    logic voice_on;
    logic div_busy;
  } dp_status_t;

  // controller states
  typedef enum logic [5:0] {
    ST_IDLE,
    ST_CHECK,
    ST_BRANCH,
    ST_M_DI,
    ST_DIV_ENV,
    ST_WAIT_ENV,
    ST_W_ENV0,
    ST_ENV_M,
    ST_ENV_W,
    ST_M_F0,
    ST_W_F0,
    ST_M_F1,
    ST_W_F1,
    ST_M_SRD,
    ST_DIV_INC,
    ST_WAIT_INC,
    ST_W_INC,
    ST_LFSR,
    ST_M_N1,
    ST_W_N1,
    ST_M_N2,
    ST_W_N2,
    ST_M_S1,
    ST_W_S1,
    ST_M_S2,
    ST_W_S2,
    ST_M_S3,
    ST_W_S3,
    ST_M_S4,
    ST_W_S4,
    ST_M_VA,
    ST_W_VA,
    ST_M_VE,
    ST_W_VE,
    ST_M_PCM,
    ST_OUT
  } ctrl_state_t;

endpackage

>>> hw/rtl/swept_tone_noise_voice_top.sv
// ----------------------------------------------------------------------------
// swept_tone_noise_voice_top
// One synth voice: swept square/saw/sine/noise tone with exponential decay.
// ----------------------------------------------------------------------------
// Each input request is one sample tick: the voice adds its sample onto
// in_mix_in and returns the saturated mix, a 16-bit pcm copy and the
// active/last flags. One request is processed at a time. A sounding sample
// runs the bit-serial divider twice, once for the envelope position and once
// for the phase increment, plus the steps on the single shared 18x18
// multiplier. The next request is accepted while the previous result still
// waits in the output register. Configuration writes are taken at any time
// (cfg_ready is always high) and must only be issued while the voice has no
// request in flight.
module swept_tone_noise_voice_top import stnv_pkg::*; #(
  parameter int SAMPLE_RATE     = 22050,
  parameter int PHASE_BITS      = 24,
  parameter int SINE_TABLE_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_start_req,
  input  logic signed [MIX_W-1:0] in_mix_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [MIX_W-1:0] out_mix_out,
  output logic signed [PCM_W-1:0] out_pcm_out,
  output logic                    out_active,
  output logic                    out_last,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // register writes never wait
  assign cfg_ready = 1'b1;

  // sequencer
  stnv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  stnv_dp #(
    .SAMPLE_RATE     (SAMPLE_RATE),
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_start_req (in_start_req),
    .in_mix_in    (in_mix_in),
    .cfg_we       (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_mix_out  (out_mix_out),
    .out_pcm_out  (out_pcm_out),
    .out_active   (out_active),
    .out_last     (out_last)
  );

endmodule

>>> hw/rtl/stnv_div.sv
// ----------------------------------------------------------------------------
// stnv_div
// Restoring unsigned divider, one quotient bit per clock.
// ----------------------------------------------------------------------------
module stnv_div #(
  parameter int NUM_W = 54,
  parameter int DEN_W = 31
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  // shift in the next numerator bit and try a subtract
  assign trial = {rem_r, q_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[DEN_W-1:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - CNT_W'(1);
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operands and partial results
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

>>> hw/rtl/stnv_dp.sv
// ----------------------------------------------------------------------------
// stnv_dp
// Voice datapath: registers, shared 18x18 multiplier, divider, output stage.
// ----------------------------------------------------------------------------
module stnv_dp import stnv_pkg::*; #(
  parameter int SAMPLE_RATE     = 22050,
  parameter int PHASE_BITS      = 24,
  parameter int SINE_TABLE_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  logic                   in_start_req,
  input  logic signed [MIX_W-1:0] in_mix_in,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic signed [MIX_W-1:0] out_mix_out,
  output logic signed [PCM_W-1:0] out_pcm_out,
  output logic                   out_active,
  output logic                   out_last
);

  localparam int SR_W  = $clog2(SAMPLE_RATE + 1);
  localparam int DEN_W = SR_W + DUR_W;
  localparam int NUM_W = SWEEP_NUM_W + PHASE_BITS;
  localparam int STB   = SINE_TABLE_BITS;
  localparam logic [STB:0] K_FULL = {1'b1, {STB{1'b0}}};

  // configuration
  logic [FREQ_W-1:0]  start_freq_r;
  logic [FREQ_W-1:0]  end_freq_r;
  logic [AMP_W-1:0]   amplitude_r;
  logic [WAVE_W-1:0]  waveform_r;
  logic [DECAY_W-1:0] decay_rate_r;
  logic [DUR_W-1:0]   duration_r;

  // voice state
  logic [DUR_W-1:0]        idx_r;
  logic [PHASE_BITS-1:0]   phase_r;
  logic [15:0]             lfsr_r;
  logic signed [15:0]      lp_r;
  logic                    on_r;

  // per-sample working registers
  logic signed [MIX_W:0]   mix_r;
  logic                    act_r;
  logic                    fin_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W:0]  acc_r;
  logic [15:0]             env_r;
  logic [ENV_FRAC_W-1:0]   xf_r;
  logic [PHASE_BITS-1:0]   inc_r;
  logic [16:0]             x2_r;
  logic [16:0]             t_r;
  logic signed [16:0]      sine_r;
  logic signed [16:0]      va_r;
  logic signed [MIX_W-1:0] mix_out_r;
  logic signed [PCM_W-1:0] pcm_out_r;
  logic                    active_r;
  logic                    last_r;

  logic [DUR_W-1:0]        dur_eff;
  logic [STB+1:0]          top_bits;
  logic [1:0]              quad;
  logic [STB:0]            sin_k;
  logic [16:0]             sin_x;
  logic signed [16:0]      wave_v;
  logic signed [17:0]      noise_w;
  logic [15:0]             lfsr_next;
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;
  logic                    mul_en;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W:0]  prod_ext;
  logic signed [PROD_W:0]  prod_rnd;
  logic signed [PROD_W:0]  lp_rnd;
  logic [17:0]             sin_half;
  logic [16:0]             sin_mag;
  logic signed [MIX_W-1:0] sat_mix;
  logic signed [16:0]      clamp_c;
  logic signed [PROD_W-1:0] pcm_full;
  logic                    div_start;
  logic [NUM_W-1:0]        div_num;
  logic [DEN_W-1:0]        div_den;
  logic                    div_busy;
  logic [NUM_W-1:0]        div_quot;
  logic                    last_hit;

  // round to nearest of x / 2^15, halves upward
  function automatic logic signed [PROD_W:0] rnd15(input logic signed [PROD_W:0] x);
    return (x + (PROD_W+1)'(16384)) >>> 15;
  endfunction

  assign dur_eff = (duration_r == '0) ? DUR_W'(1) : duration_r;

  // sine table address and mirrored argument
  assign top_bits = phase_r[PHASE_BITS-1 -: STB+2];
  assign quad     = top_bits[STB+1:STB];
  assign sin_k    = quad[0] ? (K_FULL - {1'b0, top_bits[STB-1:0]})
                            : {1'b0, top_bits[STB-1:0]};
  assign sin_x    = {sin_k, {(16-STB){1'b0}}};

  // waveform sample in Q1.15
  always_comb begin
    case (waveform_r)
      WAVE_SQUARE: wave_v = phase_r[PHASE_BITS-1] ? -17'sd32768 : 17'sd32768;
      WAVE_SAW:    wave_v = $signed({1'b0, phase_r[PHASE_BITS-1 -: 16]}) - 17'sd32768;
      WAVE_SINE:   wave_v = sine_r;
      default:     wave_v = {lp_r[15], lp_r};
    endcase
  end

  // noise source
  assign lfsr_next = {1'b0, lfsr_r[15:1]} ^ (lfsr_r[0] ? LFSR_TAPS : 16'h0000);
  assign noise_w   = $signed({2'b00, lfsr_r}) - 18'sd32768;

  // shared multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_M_DI: begin
        mul_a = $signed({8'd0, decay_rate_r});
        mul_b = $signed({2'd0, idx_r});
      end
      OP_M_ENV: begin
        mul_a = $signed({2'd0, env_r});
        mul_b = $signed({3'd0, exp_frac(cmd.env_bit)});
      end
      OP_M_F0: begin
        mul_a = $signed({4'd0, start_freq_r});
        mul_b = $signed({2'd0, dur_eff - idx_r});
      end
      OP_M_F1: begin
        mul_a = $signed({4'd0, end_freq_r});
        mul_b = $signed({2'd0, idx_r});
      end
      OP_M_SRD: begin
        mul_a = MUL_W'(SAMPLE_RATE);
        mul_b = $signed({2'd0, dur_eff});
      end
      OP_M_N1: begin
        mul_a = {{2{lp_r[15]}}, lp_r};
        mul_b = MUL_W'(LP_KEEP);
      end
      OP_M_N2: begin
        mul_a = noise_w;
        mul_b = MUL_W'(LP_NEW);
      end
      OP_M_S1: begin
        mul_a = $signed({1'b0, sin_x});
        mul_b = $signed({1'b0, sin_x});
      end
      OP_M_S2: begin
        mul_a = $signed({1'b0, x2_r});
        mul_b = MUL_W'(SIN_C);
      end
      OP_M_S3: begin
        mul_a = $signed({1'b0, x2_r});
        mul_b = $signed({1'b0, t_r});
      end
      OP_M_S4: begin
        mul_a = $signed({1'b0, sin_x});
        mul_b = $signed({1'b0, t_r});
      end
      OP_M_VA: begin
        mul_a = {wave_v[16], wave_v};
        mul_b = $signed({3'd0, amplitude_r});
      end
      OP_M_VE: begin
        mul_a = {va_r[16], va_r};
        mul_b = $signed({2'd0, env_r});
      end
      OP_M_PCM: begin
        mul_a = {clamp_c[16], clamp_c};
        mul_b = MUL_W'(PCM_SCALE);
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_ext = {prod_r[PROD_W-1], prod_r};
  assign prod_rnd = rnd15(prod_ext);
  assign lp_rnd   = rnd15(acc_r + prod_ext);
  assign sin_half = (prod_r[33:16] + 18'd1) >> 1;
  assign sin_mag  = sin_half[16:0];
  assign last_hit = ({1'b0, idx_r} + 17'd1) >= {1'b0, dur_eff};

  // output saturation, clamp and pcm scaling
  always_comb begin
    if (mix_r > 19'sd131071) begin
      sat_mix = 18'sh1FFFF;
    end else if (mix_r < -19'sd131072) begin
      sat_mix = 18'sh20000;
    end else begin
      sat_mix = mix_r[MIX_W-1:0];
    end
    if (sat_mix > 18'sd32768) begin
      clamp_c = 17'sd32768;
    end else if (sat_mix < -18'sd32768) begin
      clamp_c = -17'sd32768;
    end else begin
      clamp_c = sat_mix[16:0];
    end
  end

  assign pcm_full = prod_r[PROD_W-1] ? ((prod_r + PROD_W'(32767)) >>> 15)
                                     : (prod_r >>> 15);

  // divider operands
  assign div_start = (cmd.op == OP_DIV_ENV) || (cmd.op == OP_DIV_INC);
  assign div_num   = (cmd.op == OP_DIV_ENV) ? NUM_W'({prod_r[25:0], 2'b00})
                                            : {acc_r[SWEEP_NUM_W-1:0], {PHASE_BITS{1'b0}}};
  assign div_den   = (cmd.op == OP_DIV_ENV) ? DEN_W'(dur_eff) : prod_r[DEN_W-1:0];

  stnv_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  // configuration registers and voice state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_freq_r <= RST_START_FREQ;
      end_freq_r   <= RST_END_FREQ;
      amplitude_r  <= RST_AMPLITUDE;
      waveform_r   <= RST_WAVEFORM;
      decay_rate_r <= RST_DECAY_RATE;
      duration_r   <= RST_DURATION;
      idx_r        <= '0;
      phase_r      <= '0;
      lfsr_r       <= LFSR_SEED;
      lp_r         <= '0;
      on_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_FREQ: start_freq_r <= cfg_data[FREQ_W-1:0];
          CFG_END_FREQ:   end_freq_r   <= cfg_data[FREQ_W-1:0];
          CFG_AMPLITUDE:  amplitude_r  <= cfg_data[AMP_W-1:0];
          CFG_WAVEFORM:   waveform_r   <= cfg_data[WAVE_W-1:0];
          CFG_DECAY_RATE: decay_rate_r <= cfg_data[DECAY_W-1:0];
          CFG_DURATION:   duration_r   <= cfg_data[DUR_W-1:0];
          default: ;
        endcase
      end
      case (cmd.op)
        OP_LOAD: begin
          if (in_start_req) begin
            idx_r   <= '0;
            phase_r <= '0;
            lp_r    <= '0;
            on_r    <= 1'b1;
          end
        end
        OP_CHECK: begin
          if (on_r && (idx_r >= dur_eff)) begin
            on_r <= 1'b0;
          end
        end
        OP_LFSR: begin
          if (waveform_r == WAVE_NOISE) begin
            lfsr_r <= lfsr_next;
          end
        end
        OP_W_N2: begin
          if (waveform_r == WAVE_NOISE) begin
            lp_r <= lp_rnd[15:0];
          end
        end
        OP_W_VE: begin
          phase_r <= phase_r + inc_r;
          idx_r   <= idx_r + DUR_W'(1);
          if (last_hit) begin
            on_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_p;
    end
    case (cmd.op)
      OP_LOAD: begin
        mix_r <= {in_mix_in[MIX_W-1], in_mix_in};
        act_r <= 1'b0;
        fin_r <= 1'b0;
      end
      OP_W_ENV0: begin
        env_r <= (div_quot < NUM_W'(ENV_X_LIMIT)) ? exp_int(div_quot[9:6]) : 16'd0;
        xf_r  <= div_quot[ENV_FRAC_W-1:0];
      end
      OP_W_ENV: begin
        if (xf_r[cmd.env_bit]) begin
          env_r <= prod_rnd[15:0];
        end
      end
      OP_W_F0:  acc_r  <= prod_ext;
      OP_W_F1:  acc_r  <= acc_r + prod_ext;
      OP_W_INC: inc_r  <= div_quot[PHASE_BITS-1:0];
      OP_W_N1:  acc_r  <= prod_ext;
      OP_W_S1:  x2_r   <= prod_r[32:16];
      OP_W_S2:  t_r    <= 17'(SIN_B) - prod_r[32:16];
      OP_W_S3:  t_r    <= 17'(SIN_A) - prod_r[32:16];
      OP_W_S4:  sine_r <= quad[1] ? -$signed(sin_mag) : $signed(sin_mag);
      OP_W_VA:  va_r   <= prod_rnd[16:0];
      OP_W_VE: begin
        mix_r <= mix_r + {{2{prod_rnd[16]}}, prod_rnd[16:0]};
        act_r <= 1'b1;
        fin_r <= last_hit;
      end
      OP_OUT: begin
        mix_out_r <= sat_mix;
        pcm_out_r <= pcm_full[PCM_W-1:0];
        active_r  <= act_r;
        last_r    <= fin_r;
      end
      default: ;
    endcase
  end

  assign status.voice_on = on_r;
  assign status.div_busy = div_busy;

  assign out_mix_out = mix_out_r;
  assign out_pcm_out = pcm_out_r;
  assign out_active  = active_r;
  assign out_last    = last_r;

endmodule

>>> hw/rtl/stnv_ctrl.sv
// ----------------------------------------------------------------------------
// stnv_ctrl
// Sample sequencer: steps the datapath through one sample and runs handshakes.
// ----------------------------------------------------------------------------
module stnv_ctrl import stnv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t          state_r, state_nxt;
  logic [ENV_BIT_W-1:0] env_bit_r, env_bit_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      env_bit_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      env_bit_r   <= env_bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    env_bit_nxt   = env_bit_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = OP_NONE;
    cmd.env_bit   = env_bit_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.op    = OP_CHECK;
        state_nxt = ST_BRANCH;
      end
      ST_BRANCH:   state_nxt = status.voice_on ? ST_M_DI : ST_M_PCM;
      ST_M_DI: begin
        cmd.op    = OP_M_DI;
        state_nxt = ST_DIV_ENV;
      end
      ST_DIV_ENV: begin
        cmd.op    = OP_DIV_ENV;
        state_nxt = ST_WAIT_ENV;
      end
      ST_WAIT_ENV: begin
        if (!status.div_busy) begin
          state_nxt = ST_W_ENV0;
        end
      end
      ST_W_ENV0: begin
        cmd.op      = OP_W_ENV0;
        env_bit_nxt = '0;
        state_nxt   = ST_ENV_M;
      end
      ST_ENV_M: begin
        cmd.op    = OP_M_ENV;
        state_nxt = ST_ENV_W;
      end
      ST_ENV_W: begin
        cmd.op = OP_W_ENV;
        if (env_bit_r == ENV_BIT_W'(ENV_FRAC_W - 1)) begin
          env_bit_nxt = '0;
          state_nxt   = ST_M_F0;
        end else begin
          env_bit_nxt = env_bit_r + ENV_BIT_W'(1);
          state_nxt   = ST_ENV_M;
        end
      end
      ST_M_F0: begin
        cmd.op    = OP_M_F0;
        state_nxt = ST_W_F0;
      end
      ST_W_F0: begin
        cmd.op    = OP_W_F0;
        state_nxt = ST_M_F1;
      end
      ST_M_F1: begin
        cmd.op    = OP_M_F1;
        state_nxt = ST_W_F1;
      end
      ST_W_F1: begin
        cmd.op    = OP_W_F1;
        state_nxt = ST_M_SRD;
      end
      ST_M_SRD: begin
        cmd.op    = OP_M_SRD;
        state_nxt = ST_DIV_INC;
      end
      ST_DIV_INC: begin
        cmd.op    = OP_DIV_INC;
        state_nxt = ST_WAIT_INC;
      end
      ST_WAIT_INC: begin
        if (!status.div_busy) begin
          state_nxt = ST_W_INC;
        end
      end
      ST_W_INC: begin
        cmd.op    = OP_W_INC;
        state_nxt = ST_LFSR;
      end
      ST_LFSR: begin
        cmd.op    = OP_LFSR;
        state_nxt = ST_M_N1;
      end
      ST_M_N1: begin
        cmd.op    = OP_M_N1;
        state_nxt = ST_W_N1;
      end
      ST_W_N1: begin
        cmd.op    = OP_W_N1;
        state_nxt = ST_M_N2;
      end
      ST_M_N2: begin
        cmd.op    = OP_M_N2;
        state_nxt = ST_W_N2;
      end
      ST_W_N2: begin
        cmd.op    = OP_W_N2;
        state_nxt = ST_M_S1;
      end
      ST_M_S1: begin
        cmd.op    = OP_M_S1;
        state_nxt = ST_W_S1;
      end
      ST_W_S1: begin
        cmd.op    = OP_W_S1;
        state_nxt = ST_M_S2;
      end
      ST_M_S2: begin
        cmd.op    = OP_M_S2;
        state_nxt = ST_W_S2;
      end
      ST_W_S2: begin
        cmd.op    = OP_W_S2;
        state_nxt = ST_M_S3;
      end
      ST_M_S3: begin
        cmd.op    = OP_M_S3;
        state_nxt = ST_W_S3;
      end
      ST_W_S3: begin
        cmd.op    = OP_W_S3;
        state_nxt = ST_M_S4;
      end
      ST_M_S4: begin
        cmd.op    = OP_M_S4;
        state_nxt = ST_W_S4;
      end
      ST_W_S4: begin
        cmd.op    = OP_W_S4;
        state_nxt = ST_M_VA;
      end
      ST_M_VA: begin
        cmd.op    = OP_M_VA;
        state_nxt = ST_W_VA;
      end
      ST_W_VA: begin
        cmd.op    = OP_W_VA;
        state_nxt = ST_M_VE;
      end
      ST_M_VE: begin
        cmd.op    = OP_M_VE;
        state_nxt = ST_W_VE;
      end
      ST_W_VE: begin
        cmd.op    = OP_W_VE;
        state_nxt = ST_M_PCM;
      end
      ST_M_PCM: begin
        cmd.op    = OP_M_PCM;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // load the output register once the previous request has left
        if (!out_valid_r || !out_stall) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> sim/swept_tone_noise_voice_top_test.sv
// ----------------------------------------------------------------------------
// swept_tone_noise_voice_top_test
// Self-checking bench for the swept tone / noise voice. Every sample request
// is scored against a bit-true model of the voice kept in the bench. The
// register settings move between traffic phases, and both channels see
// random gaps and stalls plus one long output hold.
// ----------------------------------------------------------------------------
module swept_tone_noise_voice_top_test import stnv_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RATE_HZ   = 22050;
  localparam int PH_BITS   = 24;
  localparam int SINE_BITS = 8;

  localparam logic signed [MIX_W-1:0] MIX_MAX = 18'sh1FFFF;
  localparam logic signed [MIX_W-1:0] MIX_MIN = 18'sh20000;
  localparam logic [CFG_DATA_W-1:0] FREQ_TOP  = 16'd16383;
  localparam logic [CFG_DATA_W-1:0] AMP_TOP   = 16'd32767;
  localparam logic [CFG_DATA_W-1:0] DECAY_TOP = 16'd1023;
  localparam logic [CFG_DATA_W-1:0] DUR_TOP   = 16'd65535;

  // register slots with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  // noise source and lowpass weights
  localparam logic [15:0] NOISE_TAPS = 16'hB400;
  localparam longint LP_OLD_W = 19661;
  localparam longint LP_IN_W  = 13107;

  localparam int RANDOM_TICKS = 530;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 200;
  localparam int TIMEOUT_NS   = 6_000_000;

  typedef struct {
    logic                    start;
    logic signed [MIX_W-1:0] mix;
  } tick_req_t;

  typedef struct {
    logic signed [MIX_W-1:0] mix;
    logic signed [PCM_W-1:0] pcm;
    logic                    active;
    logic                    last;
  } tick_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_start_req;
  logic signed [MIX_W-1:0] in_mix_in;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [MIX_W-1:0] out_mix_out;
  logic signed [PCM_W-1:0] out_pcm_out;
  logic                    out_active;
  logic                    out_last;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  swept_tone_noise_voice_top #(
    .SAMPLE_RATE     (RATE_HZ),
    .PHASE_BITS      (PH_BITS),
    .SINE_TABLE_BITS (SINE_BITS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_start_req (in_start_req),
    .in_mix_in    (in_mix_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_mix_out  (out_mix_out),
    .out_pcm_out  (out_pcm_out),
    .out_active   (out_active),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // voice model: register copies and running state
  logic [FREQ_W-1:0]  cf_start;
  logic [FREQ_W-1:0]  cf_end;
  logic [AMP_W-1:0]   cf_amp;
  logic [WAVE_W-1:0]  cf_wave;
  logic [DECAY_W-1:0] cf_decay;
  logic [DUR_W-1:0]   cf_dur;
  logic [15:0]        tick_count;
  logic [PH_BITS-1:0] phase_now;
  logic [15:0]        lfsr_now;
  longint             lp_now;
  logic               sounding;

  // bench bookkeeping
  tick_req_t    tick_backlog[$];
  tick_result_t expected_ticks[$];
  tick_req_t    tx_item;
  tick_result_t seen;
  logic         in_fire;
  logic         no_idle;
  int unsigned  tx_gap;
  int unsigned  rx_left;
  int unsigned  hold_cycles_req;
  int unsigned  hold_left;
  int           items_total;
  int           results_done;
  int           fail_count;
  int           shown;
  int           sounding_seen;
  int           ends_seen;
  int           cfg_writes;
  int           phase_no;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // round to nearest in Q15, halves upward
  function automatic longint round_q15(input longint x);
    return (x + 16384) >>> 15;
  endfunction

  function automatic longint exp_whole(input longint k);
    case (k)
      0:       return 32768;
      1:       return 12055;
      2:       return 4435;
      3:       return 1631;
      4:       return 600;
      5:       return 221;
      6:       return 81;
      7:       return 30;
      8:       return 11;
      9:       return 4;
      10:      return 1;
      11:      return 1;
      default: return 0;
    endcase
  endfunction

  function automatic longint exp_part(input int b);
    case (b)
      0:       return 32260;
      1:       return 31760;
      2:       return 30783;
      3:       return 28918;
      4:       return 25520;
      default: return 19875;
    endcase
  endfunction

  function automatic longint sine_quarter(input longint k);
    longint x, x2, t;
    x  = k << (16 - SINE_BITS);
    x2 = (x * x) >> 16;
    t  = 42331 - ((x2 * 4923) >> 16);
    t  = 102944 - ((x2 * t) >> 16);
    return (((x * t) >> 16) + 1) >> 1;
  endfunction

  // waveform value in Q1.15; noise advances the lfsr and the lowpass
  function automatic longint wave_sample();
    longint p, top, quad, k, s, w;
    logic   lsb;
    p = longint'(phase_now);
    case (cf_wave)
      WAVE_SQUARE: return phase_now[PH_BITS-1] ? -32768 : 32768;
      WAVE_SAW:    return (p >> (PH_BITS - 16)) - 32768;
      WAVE_SINE: begin
        top  = p >> (PH_BITS - SINE_BITS - 2);
        quad = (top >> SINE_BITS) & 3;
        k    = top & ((1 << SINE_BITS) - 1);
        s    = quad[0] ? sine_quarter((1 << SINE_BITS) - k) : sine_quarter(k);
        return quad[1] ? -s : s;
      end
      default: begin
        lsb      = lfsr_now[0];
        lfsr_now = lfsr_now >> 1;
        if (lsb) lfsr_now = lfsr_now ^ NOISE_TAPS;
        w        = longint'(lfsr_now);
        w        = w - 32768;
        lp_now   = round_q15(lp_now * LP_OLD_W + w * LP_IN_W);
        return lp_now;
      end
    endcase
  endfunction

  // exp(-decay*i/(16*d)) in Q1.15, position in 1/64 steps
  function automatic longint decay_gain(input longint i, input longint d);
    longint x, g, rate;
    rate = longint'(cf_decay);
    x = (rate * i * 4) / d;
    g = ((x >> 6) < 12) ? exp_whole(x >> 6) : 0;
    for (int b = 0; b < 6; b++) begin
      if (x[b]) g = round_q15(g * exp_part(b));
    end
    return g;
  endfunction

  // one sample tick of the voice
  function automatic tick_result_t voice_tick(input logic start,
                                              input logic signed [MIX_W-1:0] mix_in);
    tick_result_t r;
    longint d, i, mix, v, g, vs, f0, f1, amp, num, inc, c;
    d   = (cf_dur == '0) ? longint'(1) : longint'(cf_dur);
    mix = longint'(mix_in);
    f0  = longint'(cf_start);
    f1  = longint'(cf_end);
    amp = longint'(cf_amp);
    r.active = 1'b0;
    r.last   = 1'b0;
    if (start) begin
      tick_count = '0;
      phase_now  = '0;
      lp_now     = 0;
      sounding   = 1'b1;
    end
    i = longint'(tick_count);
    if (sounding && i >= d) sounding = 1'b0;
    if (sounding) begin
      v   = wave_sample();
      g   = decay_gain(i, d);
      vs  = round_q15(round_q15(v * amp) * g);
      num = f0 * (d - i) + f1 * i;
      inc = (num << PH_BITS) / (RATE_HZ * d);
      phase_now = phase_now + inc[PH_BITS-1:0];
      mix = mix + vs;
      r.active = 1'b1;
      if (i + 1 >= d) begin
        r.last   = 1'b1;
        sounding = 1'b0;
      end
      tick_count = 16'(i + 1);
    end
    if (mix > 131071) mix = 131071;
    if (mix < -131072) mix = -131072;
    c = (mix > 32768) ? 32768 : ((mix < -32768) ? -32768 : mix);
    c = (c * PCM_SCALE) / 32768;
    r.mix = mix[MIX_W-1:0];
    r.pcm = c[PCM_W-1:0];
    return r;
  endfunction

  // gap lengths: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 20);
    return $urandom_range(40, 160);
  endfunction

  function automatic logic signed [MIX_W-1:0] rand_mix();
    case ($urandom_range(0, 9))
      0:       return MIX_MAX;
      1:       return MIX_MIN;
      2:       return MIX_W'($signed($urandom_range(0, 4000)) - 2000);
      default: return MIX_W'($urandom());
    endcase
  endfunction

  // request driver, fed from the backlog
  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (tx_gap != 0 && !no_idle) begin
        tx_gap = tx_gap - 1;
        in_valid <= 1'b0;
      end else if (tick_backlog.size() != 0) begin
        tx_item = tick_backlog.pop_front();
        in_valid     <= 1'b1;
        in_start_req <= tx_item.start;
        in_mix_in    <= tx_item.mix;
        tx_gap = idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall pattern, forced high during a hold
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else if (rx_left != 0) begin
      rx_left = rx_left - 1;
    end else if ($urandom_range(0, 1) != 0) begin
      out_stall <= 1'b1;
      rx_left = idle_len();
    end else begin
      out_stall <= 1'b0;
      rx_left = $urandom_range(0, 12);
    end
  end

  // long output hold, counted in cycles
  always @(posedge clk) begin
    if (hold_cycles_req != 0) begin
      hold_left       = hold_cycles_req;
      hold_cycles_req = 0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
    end
  end

  // monitor: register writes, result scoring, prediction of accepted requests
  always @(posedge clk) begin
    in_fire = rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        cfg_writes += 1;
        case (cfg_index)
          CFG_START_FREQ: cf_start = cfg_data[FREQ_W-1:0];
          CFG_END_FREQ:   cf_end   = cfg_data[FREQ_W-1:0];
          CFG_AMPLITUDE:  cf_amp   = cfg_data[AMP_W-1:0];
          CFG_WAVEFORM:   cf_wave  = cfg_data[WAVE_W-1:0];
          CFG_DECAY_RATE: cf_decay = cfg_data[DECAY_W-1:0];
          CFG_DURATION:   cf_dur   = cfg_data[DUR_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_done += 1;
        if (expected_ticks.size() == 0) begin
          fail_count += 1;
          if (shown < 10) begin
            shown += 1;
            $display("result %0d with no request waiting: mix %0d pcm %0d",
                     results_done, out_mix_out, out_pcm_out);
          end
        end else begin
          seen = expected_ticks.pop_front();
          if (out_mix_out !== seen.mix || out_pcm_out !== seen.pcm ||
              out_active !== seen.active || out_last !== seen.last) begin
            fail_count += 1;
            if (shown < 10) begin
              shown += 1;
              $display("result %0d mismatch: mix %0d/%0d pcm %0d/%0d active %b/%b last %b/%b",
                       results_done, seen.mix, out_mix_out, seen.pcm, out_pcm_out,
                       seen.active, out_active, seen.last, out_last);
            end
          end
          if (seen.active) sounding_seen += 1;
          if (seen.last) ends_seen += 1;
        end
      end
      if (in_fire) expected_ticks.push_back(voice_tick(in_start_req, in_mix_in));
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // end of register writes; requests are queued from a rising edge on
  task automatic open_traffic();
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_tick(input logic start, input logic signed [MIX_W-1:0] mix);
    tick_req_t t;
    t.start = start;
    t.mix   = mix;
    tick_backlog.push_back(t);
    items_total += 1;
  endtask

  // wait until every queued request has come back
  task automatic settle();
    while (results_done < items_total) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // occasionally write a raw 16-bit word so the unused upper bits toggle
  function automatic logic [CFG_DATA_W-1:0] maybe_raw(input logic [CFG_DATA_W-1:0] val);
    return ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom()) : val;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_freq();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return FREQ_TOP;
      2:       return 16'd11025;
      3, 4:    return CFG_DATA_W'($urandom_range(20, 2000));
      default: return CFG_DATA_W'($urandom_range(0, FREQ_TOP));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_duration();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'd0;
    if (r < 8) return DUR_TOP;
    if (r < 18) return CFG_DATA_W'($urandom_range(41, 300));
    return CFG_DATA_W'($urandom_range(1, 40));
  endfunction

  task automatic write_random_config();
    logic [CFG_DATA_W-1:0] amp, decay;
    case ($urandom_range(0, 9))
      0:       amp = 16'd0;
      1, 2:    amp = AMP_TOP;
      default: amp = CFG_DATA_W'($urandom_range(0, AMP_TOP));
    endcase
    case ($urandom_range(0, 9))
      0:       decay = 16'd0;
      1:       decay = DECAY_TOP;
      default: decay = CFG_DATA_W'($urandom_range(0, DECAY_TOP));
    endcase
    write_reg(CFG_START_FREQ, maybe_raw(pick_freq()));
    write_reg(CFG_END_FREQ, maybe_raw(pick_freq()));
    write_reg(CFG_AMPLITUDE, maybe_raw(amp));
    write_reg(CFG_WAVEFORM, maybe_raw(CFG_DATA_W'($urandom_range(0, 3))));
    write_reg(CFG_DECAY_RATE, maybe_raw(decay));
    write_reg(CFG_DURATION, pick_duration());
  endtask

  initial begin
    int unsigned n;
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_start_req    = 1'b0;
    in_mix_in       = '0;
    out_stall       = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_fire         = 1'b0;
    no_idle         = 1'b0;
    tx_gap          = 0;
    rx_left         = 0;
    hold_cycles_req = 0;
    hold_left       = 0;
    items_total     = 0;
    results_done    = 0;
    fail_count      = 0;
    shown           = 0;
    sounding_seen   = 0;
    ends_seen       = 0;
    cfg_writes      = 0;
    phase_no        = 0;
    // model state after reset
    cf_start   = RST_START_FREQ;
    cf_end     = RST_END_FREQ;
    cf_amp     = RST_AMPLITUDE;
    cf_wave    = RST_WAVEFORM;
    cf_decay   = RST_DECAY_RATE;
    cf_dur     = RST_DURATION;
    tick_count = '0;
    phase_now  = '0;
    lfsr_now   = 16'hACE1;
    lp_now     = 0;
    sounding   = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // idle voice: the mix passes through, pcm clamps at both ends
    open_traffic();
    add_tick(1'b0, MIX_MAX);
    add_tick(1'b0, MIX_MIN);
    settle();

    // zero duration sounds one sample; full square saturates the mix
    write_reg(CFG_START_FREQ, 16'd0);
    write_reg(CFG_END_FREQ, FREQ_TOP);
    write_reg(CFG_AMPLITUDE, AMP_TOP);
    write_reg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_SQUARE));
    write_reg(CFG_DECAY_RATE, 16'd0);
    write_reg(CFG_DURATION, 16'd0);
    write_reg(CFG_SPARE_6, 16'hFFFF);
    write_reg(CFG_SPARE_7, 16'h5A5A);
    open_traffic();
    add_tick(1'b1, MIX_MAX);
    add_tick(1'b0, MIX_MIN);
    settle();

    // saw swept downward with the fastest decay
    write_reg(CFG_START_FREQ, FREQ_TOP);
    write_reg(CFG_END_FREQ, 16'd0);
    write_reg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_SAW));
    write_reg(CFG_DECAY_RATE, DECAY_TOP);
    write_reg(CFG_DURATION, 16'd4);
    open_traffic();
    add_tick(1'b1, MIX_MIN);
    add_tick(1'b0, -18'sd1);
    add_tick(1'b0, 18'sd1);
    add_tick(1'b0, 18'sd0);
    settle();

    // sine at the top audio frequency
    write_reg(CFG_START_FREQ, 16'd11025);
    write_reg(CFG_END_FREQ, 16'd11025);
    write_reg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_SINE));
    write_reg(CFG_DECAY_RATE, 16'd96);
    write_reg(CFG_DURATION, 16'd6);
    open_traffic();
    add_tick(1'b1, 18'sd0);
    add_tick(1'b0, 18'sd0);
    add_tick(1'b0, 18'sd32768);
    settle();

    // noise, restarted while still sounding
    write_reg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_NOISE));
    write_reg(CFG_AMPLITUDE, 16'd16384);
    write_reg(CFG_DURATION, 16'd5);
    open_traffic();
    add_tick(1'b1, rand_mix());
    add_tick(1'b0, rand_mix());
    add_tick(1'b0, rand_mix());
    add_tick(1'b1, rand_mix());
    add_tick(1'b0, rand_mix());
    add_tick(1'b0, rand_mix());
    settle();

    // duration shrunk below the current sample index while sounding
    write_reg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_SAW));
    write_reg(CFG_DURATION, 16'd12);
    open_traffic();
    add_tick(1'b1, rand_mix());
    add_tick(1'b0, rand_mix());
    add_tick(1'b0, rand_mix());
    add_tick(1'b0, rand_mix());
    settle();
    write_reg(CFG_DURATION, 16'd3);
    open_traffic();
    add_tick(1'b0, rand_mix());
    add_tick(1'b0, rand_mix());
    settle();

    // longest duration
    write_reg(CFG_WAVEFORM, CFG_DATA_W'(WAVE_SINE));
    write_reg(CFG_AMPLITUDE, AMP_TOP);
    write_reg(CFG_START_FREQ, 16'd1);
    write_reg(CFG_END_FREQ, 16'd11025);
    write_reg(CFG_DURATION, DUR_TOP);
    open_traffic();
    add_tick(1'b1, rand_mix());
    add_tick(1'b0, rand_mix());
    add_tick(1'b0, rand_mix());
    settle();

    // random phases: new settings, then a start followed by ticks
    while (items_total < RANDOM_TICKS) begin
      phase_no += 1;
      @(posedge clk);
      no_idle = (phase_no % 5 == 0) || (phase_no == 3);
      write_random_config();
      open_traffic();
      n = $urandom_range(15, 40);
      // most phases start the voice, a few carry the previous one on
      add_tick($urandom_range(0, 9) != 0, rand_mix());
      for (int k = 1; k < n; k++) begin
        add_tick($urandom_range(0, 24) == 0, rand_mix());
      end
      // hold the output long enough for the input to back up
      if (phase_no == 3) begin
        @(negedge clk);
        hold_cycles_req = HOLD_CYCLES;
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (expected_ticks.size() != 0) begin
      fail_count += expected_ticks.size();
      $display("%0d expected results never came out", expected_ticks.size());
    end
    $display("covered %0d ticks, %0d sounding and %0d voice ends, over %0d register writes",
             results_done, sounding_seen, ends_seen, cfg_writes);
    $display("%0d random setting phases, one output hold of %0d cycles, %0d failures",
             phase_no, HOLD_CYCLES, fail_count);
    if (fail_count == 0) begin
      $display("swept_tone_noise_voice_top_test: clean");
    end else begin
      $display("swept_tone_noise_voice_top_test: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d of %0d results back", results_done, items_total);
    $display("swept_tone_noise_voice_top_test: errors");
    $finish;
  end

endmodule
